### src/sound_voice_allocator_core_defines.svh
// Assertion macros used by the allocator core RTL.
`ifndef SOUND_VOICE_ALLOCATOR_CORE_DEFINES_SVH
`define SOUND_VOICE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define SVAC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define SVAC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SVAC_ASSERT(lbl, clk, rst_n, prop, msg)

`define SVAC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### src/svac_pkg.sv
`default_nettype none

package svac_pkg;

	localparam int NUM_VOICES = 8;
	localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	localparam logic signed [31:0] HORIZON_TICKS = 32'sd3600000;

	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_STOP    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [3:0] CHAN_NONE = 4'h0;
	localparam logic [3:0] CHAN_ANY  = 4'hF;

	typedef struct packed {
		logic [15:0] owner;
		logic [3:0]  channel;
		logic [31:0] end_time;
	} voice_entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		voice_entry_t     wr_data;
		logic             clr_en;
		logic [IDX_W-1:0] clr_addr;
	} mem_cmd_t;

	typedef struct packed {
		logic       granted;
		logic [2:0] voice;
		logic       evicted_active;
		logic       stopped;
	} result_t;

endpackage

`default_nettype wire

### src/sound_voice_allocator_core.sv
// Voice allocator for a fixed pool of playback voices.
// Input channel s_*: one request item per handshake; s_tuser carries the request
// kind (start, stop by entity/channel, release by index), s_tdata the operands.
// Output channel m_*: exactly one result item per request, in request order.
// cfg_we/cfg_wdata write the protected player entity; write only while idle.
// Voice state (owner, channel, end time) sits in a synchronous RAM with a
// registered read; valid and playing flags are flops beside it.
// Start and stop requests walk the RAM one entry per cycle until a matching
// voice ends the walk early or the last entry has been evaluated. Release and
// unused kinds skip the walk and go straight to the result.
// The next item is accepted as soon as the previous result has been loaded into
// the output register, even while that result still waits on m_tready.
// If the receiver stalls, a finished result holds in the allocator until the
// output register frees, and no new item is accepted meanwhile.
// Reset clears all voices to idle with zero owner, channel and end time, and
// sets the player entity to 1; no clearing sweep is needed.
`default_nettype none

`include "sound_voice_allocator_core_defines.svh"

module sound_voice_allocator_core
	import svac_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,   // player_entity
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// entity[15:0], entity_channel[19:16], current_time[51:20],
	// sound_duration[75:52], voice_index[78:76], zero[79]
	input  wire logic [79:0] s_tdata,
	input  wire logic [1:0]  s_tuser,     // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// granted[0], voice[3:1], evicted_active[4], stopped[5], zero[7:6]
	output logic [7:0]       m_tdata
);

	logic [15:0]           player_q;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  res_valid;
	logic                  res_ready;
	result_t               res;
	mem_cmd_t              cmd;
	voice_entry_t          rd_data;
	logic [NUM_VOICES-1:0] playing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_q <= 16'd1;
		end else if (cfg_we) begin
			player_q <= cfg_wdata;
		end
	end

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= {2'b00, res.stopped, res.evicted_active, res.voice, res.granted};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	svac_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.player_entity  (player_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.req_type       (s_tuser),
		.entity         (s_tdata[15:0]),
		.entity_channel (s_tdata[19:16]),
		.current_time   (s_tdata[51:20]),
		.sound_duration (s_tdata[75:52]),
		.voice_index    (s_tdata[78:76]),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.cmd            (cmd),
		.rd_data        (rd_data),
		.playing        (playing)
	);

	svac_voice_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd_data),
		.playing (playing)
	);

	`SVAC_ASSERT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "accepted while busy")
	`SVAC_ASSERT(a_out_from_result, clk, arst_n, $rose(m_tvalid) |-> $past(res_valid), "output without result")
	`SVAC_NEVER(a_evict_needs_grant, clk, arst_n, m_tvalid && m_tdata[4] && !m_tdata[0], "eviction without grant")
	`SVAC_NEVER(a_grant_not_stop, clk, arst_n, m_tvalid && m_tdata[0] && m_tdata[5], "grant and stop together")

endmodule

`default_nettype wire

### src/svac_voice_mem.sv
`default_nettype none

module svac_voice_mem
	import svac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mem_cmd_t              cmd,
	output voice_entry_t               rd_data,
	output logic [NUM_VOICES-1:0]      playing
);

	voice_entry_t              voice_mem_q [NUM_VOICES];
	voice_entry_t              rd_data_s1;
	logic                      rd_valid_s1;
	logic [NUM_VOICES-1:0]     valid_q;
	logic [NUM_VOICES-1:0]     playing_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			voice_mem_q[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= voice_mem_q[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			playing_q   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_valid_s1 <= valid_q[cmd.rd_addr];
			end
			if (cmd.wr_en) begin
				valid_q[cmd.wr_addr]   <= 1'b1;
				playing_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.clr_en) begin
				playing_q[cmd.clr_addr] <= 1'b0;
			end
		end
	end

	// never-written entries read as zero
	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;
	assign playing = playing_q;

endmodule

`default_nettype wire

### src/svac_scan.sv
`default_nettype none

module svac_scan
	import svac_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [15:0]           player_entity,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            req_type,
	input  wire logic [15:0]           entity,
	input  wire logic signed [3:0]     entity_channel,
	input  wire logic [31:0]           current_time,
	input  wire logic [23:0]           sound_duration,
	input  wire logic [2:0]            voice_index,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output result_t                    res,
	output mem_cmd_t                   cmd,
	input  wire voice_entry_t          rd_data,
	input  wire logic [NUM_VOICES-1:0] playing
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

	state_t                  state_q;
	logic [1:0]              req_q;
	logic [15:0]             ent_q;
	logic [3:0]              ch_q;
	logic [31:0]             now_q;
	logic [23:0]             dur_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    issue_q;
	logic                    eval_v_s1;
	logic [IDX_W-1:0]        eval_idx_s1;
	logic                    found_q;
	logic [IDX_W-1:0]        best_q;
	logic signed [31:0]      best_rem_q;

	logic                    is_start;
	logic                    hit;
	logic                    prot;
	logic signed [31:0]      rem;
	logic                    better;
	logic                    last_eval;
	logic                    best_play;
	logic                    fin_go;

	assign is_start  = (req_q == REQ_START);
	assign rem       = signed'(rd_data.end_time - now_q);
	assign prot      = (rd_data.owner == player_entity) && (ent_q != player_entity)
		&& playing[eval_idx_s1];
	assign better    = !prot && (rem < best_rem_q);
	assign last_eval = (eval_idx_s1 == LAST_IDX);

	always_comb begin
		if (is_start) begin
			hit = (ch_q != CHAN_NONE) && (rd_data.owner == ent_q)
				&& ((ch_q == CHAN_ANY) || (rd_data.channel == ch_q));
		end else begin
			hit = (rd_data.owner == ent_q) && (rd_data.channel == ch_q);
		end
	end

	assign best_play = playing[best_q];
	assign fin_go    = (state_q == ST_FIN) && res_ready;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);

	always_comb begin
		res.granted        = is_start && found_q;
		res.voice          = found_q ? 3'(best_q) : 3'd0;
		res.evicted_active = is_start && found_q && best_play;
		res.stopped        = !is_start && found_q && best_play;
	end

	always_comb begin
		cmd.rd_en            = (state_q == ST_SCAN) && issue_q;
		cmd.rd_addr          = idx_q;
		cmd.wr_en            = fin_go && is_start && found_q;
		cmd.wr_addr          = best_q;
		cmd.wr_data.owner    = ent_q;
		cmd.wr_data.channel  = ch_q;
		cmd.wr_data.end_time = now_q + {8'd0, dur_q};
		cmd.clr_en           = fin_go && !is_start && found_q;
		cmd.clr_addr         = best_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_START;
			ent_q       <= '0;
			ch_q        <= '0;
			now_q       <= '0;
			dur_q       <= '0;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			eval_v_s1   <= 1'b0;
			eval_idx_s1 <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_rem_q  <= HORIZON_TICKS;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q      <= req_type;
						ent_q      <= entity;
						ch_q       <= entity_channel;
						now_q      <= current_time;
						dur_q      <= sound_duration;
						idx_q      <= '0;
						eval_v_s1  <= 1'b0;
						best_rem_q <= HORIZON_TICKS;
						if (req_type == REQ_START || req_type == REQ_STOP) begin
							found_q <= 1'b0;
							best_q  <= '0;
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end else if (req_type == REQ_RELEASE) begin
							found_q <= (32'(voice_index) < 32'(NUM_VOICES));
							best_q  <= IDX_W'(voice_index);
							issue_q <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							found_q <= 1'b0;
							best_q  <= '0;
							issue_q <= 1'b0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (eval_v_s1 && (hit || last_eval)) begin
						// walk done: drop the read side
						issue_q   <= 1'b0;
						eval_v_s1 <= 1'b0;
						state_q   <= ST_FIN;
					end else begin
						// advance the read side one entry per cycle
						eval_v_s1 <= issue_q;
						if (issue_q) begin
							eval_idx_s1 <= idx_q;
							if (idx_q == LAST_IDX) begin
								issue_q <= 1'b0;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
					// evaluate the entry read last cycle
					if (eval_v_s1) begin
						if (hit) begin
							found_q <= 1'b1;
							best_q  <= eval_idx_s1;
						end else if (is_start && better) begin
							found_q    <= 1'b1;
							best_q     <= eval_idx_s1;
							best_rem_q <= rem;
						end
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
